>>> src/rhhi_pkg.sv
// ----------------------------------------------------------------------------
// rhhi_pkg
// shared widths, codes and types for the robin hood insert unit
// ----------------------------------------------------------------------------
`default_nettype none

package rhhi_pkg;

  localparam int unsigned MaxSlots = 1024;
  localparam int unsigned SlotW    = $clog2(MaxSlots);
  localparam int unsigned CntW     = SlotW + 1;
  localparam int unsigned KeyW     = 40;
  localparam int unsigned PayW     = 32;
  localparam int unsigned DistW    = SlotW;
  localparam int unsigned CfgW     = 11;
  localparam int unsigned LenW     = $clog2(KeyW + 1);

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StZeroKey  = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StRange    = 2'd3;

  localparam logic [1:0] RegSlots   = 2'd0;
  localparam logic [1:0] RegPrime   = 2'd1;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdRead   = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [PayW-1:0]  pay;
    logic [DistW-1:0] pdist;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [KeyW-1:0]  dividend;
    logic [CfgW-1:0]  divisor;
    logic [LenW-1:0]  len;
  } mod_req_t;

endpackage

`default_nettype wire

>>> src/robin_hood_hash_insert_unit.sv
// ----------------------------------------------------------------------------
// robin_hood_hash_insert_unit
// robin hood open-addressing table, linear probing, insert and slot read
// ----------------------------------------------------------------------------
//  channel  direction  handshake              word
//  in       input      in_valid_i/in_ready_o  cmd, key, payload, slot
//  out      output     out_valid_o/out_ready_i status, placed slot, read fields, load
//  cfg      input      cfg_valid_i/cfg_ready_o index, data (always ready)
//
//  insert: key mod prime, then the wrap by slots in use, then a read and an
//  evaluate state per probed slot, then the output register loads. read: a
//  table read. one word in flight; the next word is taken in the cycle after
//  the result loads; the table memory port sets the probe rate. after reset a
//  clearing pass over all 1024 slots empties the table; no word is taken
//  meanwhile. a stalled output holds the finished word in its register.
// ----------------------------------------------------------------------------
`default_nettype none

module robin_hood_hash_insert_unit (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              cmd_i,
  input  wire  [rhhi_pkg::KeyW-1:0]        key_i,
  input  wire  [rhhi_pkg::PayW-1:0]        payload_i,
  input  wire  [rhhi_pkg::SlotW-1:0]       slot_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [1:0]                       status_o,
  output logic [rhhi_pkg::SlotW-1:0]       placed_slot_o,
  output logic [rhhi_pkg::KeyW-1:0]        read_key_o,
  output logic [rhhi_pkg::PayW-1:0]        read_payload_o,
  output logic [rhhi_pkg::DistW-1:0]       read_distance_o,
  output logic                             load_reached_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [1:0]                       cfg_index_i,
  input  wire  [rhhi_pkg::CfgW-1:0]        cfg_data_i
);

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SMod1  = 3'd2;
  localparam logic [2:0] SMod2  = 3'd3;
  localparam logic [2:0] SPrd   = 3'd4;
  localparam logic [2:0] SPev   = 3'd5;
  localparam logic [2:0] SRdw   = 3'd6;
  localparam logic [2:0] SDone  = 3'd7;

  logic [2:0] state_q, state_d;

  logic [rhhi_pkg::CfgW-1:0]  slots_q, prime_q;
  logic [rhhi_pkg::CfgW-1:0]  n_eff, p_eff;
  logic [rhhi_pkg::CntW-1:0]  clr_q, clr_d;
  logic [rhhi_pkg::CntW-1:0]  count_q, count_d;

  rhhi_pkg::entry_t          car_q, car_d;
  logic [rhhi_pkg::SlotW-1:0] pos_q, pos_d;
  logic                       rested_q, rested_d;

  logic [1:0]                 rstat_q, rstat_d;
  logic [rhhi_pkg::SlotW-1:0] rplaced_q, rplaced_d;
  rhhi_pkg::entry_t          rread_q, rread_d;

  logic                       out_valid_q, out_valid_d;
  logic [1:0]                 o_status_q;
  logic [rhhi_pkg::SlotW-1:0] o_placed_q;
  rhhi_pkg::entry_t          o_read_q;
  logic                       o_load_q;
  logic                       out_load;
  logic                       load_flag;

  rhhi_pkg::entry_t          mem [rhhi_pkg::MaxSlots];
  rhhi_pkg::entry_t          rdata_q;
  logic [rhhi_pkg::SlotW-1:0] raddr;
  logic                       we;
  logic [rhhi_pkg::SlotW-1:0] waddr;
  rhhi_pkg::entry_t          wdata;

  rhhi_pkg::mod_req_t        mreq;
  logic                       mdone;
  logic [rhhi_pkg::CfgW-1:0]  mrem;
  logic [rhhi_pkg::SlotW-1:0] pos_inc;

  // register clamps
  always_comb begin
    if (slots_q == '0) begin
      n_eff = rhhi_pkg::CfgW'(1);
    end else if (slots_q > rhhi_pkg::CfgW'(rhhi_pkg::MaxSlots)) begin
      n_eff = rhhi_pkg::CfgW'(rhhi_pkg::MaxSlots);
    end else begin
      n_eff = slots_q;
    end
    p_eff = (prime_q == '0) ? rhhi_pkg::CfgW'(1) : prime_q;
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= rhhi_pkg::CfgW'(1024);
      prime_q <= rhhi_pkg::CfgW'(1021);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == rhhi_pkg::RegSlots) begin
        slots_q <= cfg_data_i;
      end else if (cfg_index_i == rhhi_pkg::RegPrime) begin
        prime_q <= cfg_data_i;
      end
    end
  end

  rhhi_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .done_o (mdone),
    .rem_o  (mrem)
  );

  assign in_ready_o = (state_q == SIdle);
  assign pos_inc    = pos_q + 1'b1;
  assign out_load   = (state_q == SDone) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    count_d     = count_q;
    car_d       = car_q;
    pos_d       = pos_q;
    rested_d    = rested_q;
    rstat_d     = rstat_q;
    rplaced_d   = rplaced_q;
    rread_d     = rread_q;
    mreq        = '0;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = car_q;
    raddr       = pos_q;
    unique case (state_q)
      SClear: begin
        we    = 1'b1;
        waddr = clr_q[rhhi_pkg::SlotW-1:0];
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == rhhi_pkg::CntW'(rhhi_pkg::MaxSlots - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        raddr = slot_i;
        if (in_valid_i) begin
          rstat_d   = rhhi_pkg::StOk;
          rplaced_d = '0;
          rread_d   = '0;
          car_d.key   = key_i;
          car_d.pay   = payload_i;
          car_d.pdist = '0;
          rested_d    = 1'b0;
          if (cmd_i == rhhi_pkg::CmdRead) begin
            if ({1'b0, slot_i} >= n_eff) begin
              rstat_d = rhhi_pkg::StRange;
              state_d = SDone;
            end else begin
              state_d = SRdw;
            end
          end else if (key_i == '0) begin
            rstat_d = rhhi_pkg::StZeroKey;
            state_d = SDone;
          end else if (count_q >= n_eff) begin
            rstat_d = rhhi_pkg::StFull;
            state_d = SDone;
          end else begin
            mreq.start    = 1'b1;
            mreq.dividend = key_i;
            mreq.divisor  = p_eff;
            mreq.len      = rhhi_pkg::LenW'(rhhi_pkg::KeyW);
            state_d       = SMod1;
          end
        end
      end
      SMod1: begin
        if (mdone) begin
          // home slot further reduced by slots in use
          mreq.start    = 1'b1;
          mreq.dividend = {mrem, {(rhhi_pkg::KeyW - rhhi_pkg::CfgW){1'b0}}};
          mreq.divisor  = n_eff;
          mreq.len      = rhhi_pkg::LenW'(rhhi_pkg::CfgW);
          state_d       = SMod2;
        end
      end
      SMod2: begin
        if (mdone) begin
          pos_d   = mrem[rhhi_pkg::SlotW-1:0];
          state_d = SPrd;
        end
      end
      SPrd: begin
        state_d = SPev;
      end
      SPev: begin
        if (rdata_q.key == '0) begin
          we      = 1'b1;
          count_d = count_q + 1'b1;
          if (!rested_q) begin
            rplaced_d = pos_q;
          end
          state_d = SDone;
        end else begin
          if (rdata_q.pdist < car_q.pdist) begin
            we          = 1'b1;
            car_d       = rdata_q;
            car_d.pdist = rdata_q.pdist + 1'b1;
            if (!rested_q) begin
              rplaced_d = pos_q;
              rested_d  = 1'b1;
            end
          end else begin
            car_d.pdist = car_q.pdist + 1'b1;
          end
          pos_d   = ({1'b0, pos_inc} >= n_eff || pos_inc == '0) ? '0 : pos_inc;
          state_d = SPrd;
        end
      end
      SRdw: begin
        rread_d = rdata_q;
        state_d = SDone;
      end
      SDone: begin
        if (out_load) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign load_flag = {count_q, 2'b00} >= ({1'b0, n_eff, 1'b0} + {2'b00, n_eff});

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      count_q     <= '0;
      rested_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      rested_q    <= rested_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    car_q     <= car_d;
    pos_q     <= pos_d;
    rstat_q   <= rstat_d;
    rplaced_q <= rplaced_d;
    rread_q   <= rread_d;
    if (out_load) begin
      o_status_q <= rstat_q;
      o_placed_q <= rplaced_q;
      o_read_q   <= rread_q;
      o_load_q   <= load_flag;
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = o_status_q;
  assign placed_slot_o   = o_placed_q;
  assign read_key_o      = o_read_q.key;
  assign read_payload_o  = o_read_q.pay;
  assign read_distance_o = o_read_q.pdist;
  assign load_reached_o  = o_load_q;

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SClear) |-> !in_ready_o)
    else $error("word taken during clearing pass");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rhhi_pkg::CntW'(rhhi_pkg::MaxSlots))
    else $error("entry count above table size");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(state_q == SPev) && $past(rdata_q.key == '0))
    else $error("entry count moved outside a placement");

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SPrd) |-> ({1'b0, pos_q} < n_eff))
    else $error("probe position beyond slots in use");

endmodule

`default_nettype wire

>>> src/rhhi_mod_unit.sv
// ----------------------------------------------------------------------------
// rhhi_mod_unit
// bit-serial remainder unit, one dividend bit per cycle, msb first
// ----------------------------------------------------------------------------
`default_nettype none

module rhhi_mod_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  rhhi_pkg::mod_req_t           req_i,
  output logic                         done_o,
  output logic [rhhi_pkg::CfgW-1:0]    rem_o
);

  logic [rhhi_pkg::CfgW-1:0] rem_q, rem_d;
  logic [rhhi_pkg::KeyW-1:0] dvd_q, dvd_d;
  logic [rhhi_pkg::CfgW-1:0] div_q, div_d;
  logic [rhhi_pkg::LenW-1:0] cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [rhhi_pkg::CfgW:0]   trial;
  logic [rhhi_pkg::CfgW:0]   diff;

  assign trial = {rem_q, dvd_q[rhhi_pkg::KeyW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      cnt_d  = req_i.len;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // restoring step, remainder stays below the divisor
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[rhhi_pkg::CfgW-1:0];
      end else begin
        rem_d = trial[rhhi_pkg::CfgW-1:0];
      end
      dvd_d = {dvd_q[rhhi_pkg::KeyW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == rhhi_pkg::LenW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("remainder done without a running division");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> req_i.len != '0 && req_i.divisor != '0)
    else $error("division started with zero length or zero divisor");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < div_q)
    else $error("remainder not below divisor");

endmodule

`default_nettype wire

>>> sim/robin_hood_hash_insert_unit_tb.sv
// ----------------------------------------------------------------------------
// robin_hood_hash_insert_unit_tb
// self-checking bench for the robin hood insert unit: a directed table of
// edge cases, then phases of random inserts and slot reads under several table
// sizes and moduli, with random gaps on both channels; every result word is
// compared against a behavioral table kept in the bench or, for some directed
// rows, against a fixed expected status and load flag
`default_nettype none

module robin_hood_hash_insert_unit_tb;

  localparam int unsigned IdleLimit = 40000;
  localparam int unsigned NumPhases = 9;
  localparam int unsigned PerPhase  = 100;

  typedef struct packed {
    logic [1:0]                 status;
    logic [rhhi_pkg::SlotW-1:0] placed;
    logic [rhhi_pkg::KeyW-1:0]  rkey;
    logic [rhhi_pkg::PayW-1:0]  rpay;
    logic [rhhi_pkg::DistW-1:0] rdist;
    logic                       load;
  } result_t;

  typedef struct packed {
    logic                       do_cfg;
    logic [rhhi_pkg::CfgW-1:0]  cfg_slots;
    logic [rhhi_pkg::CfgW-1:0]  cfg_prime;
    logic                       cmd;
    logic [rhhi_pkg::KeyW-1:0]  key;
    logic [rhhi_pkg::PayW-1:0]  pay;
    logic [rhhi_pkg::SlotW-1:0] slot;
    logic                       fixed;
    logic [1:0]                 fix_status;
    logic                       fix_load;
  } row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       cmd_i = rhhi_pkg::CmdInsert;
  logic [rhhi_pkg::KeyW-1:0]  key_i = '0;
  logic [rhhi_pkg::PayW-1:0]  payload_i = '0;
  logic [rhhi_pkg::SlotW-1:0] slot_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [1:0]                 status_o;
  logic [rhhi_pkg::SlotW-1:0] placed_slot_o;
  logic [rhhi_pkg::KeyW-1:0]  read_key_o;
  logic [rhhi_pkg::PayW-1:0]  read_payload_o;
  logic [rhhi_pkg::DistW-1:0] read_distance_o;
  logic                       load_reached_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [1:0]                 cfg_index_i = rhhi_pkg::RegSlots;
  logic [rhhi_pkg::CfgW-1:0]  cfg_data_i = '0;

  // bench copy of the table
  logic [rhhi_pkg::KeyW-1:0]  key_tbl  [rhhi_pkg::MaxSlots];
  logic [rhhi_pkg::PayW-1:0]  pay_tbl  [rhhi_pkg::MaxSlots];
  logic [rhhi_pkg::DistW-1:0] dist_tbl [rhhi_pkg::MaxSlots];
  bit                         held_key [rhhi_pkg::MaxSlots];
  int unsigned                entries;
  logic [rhhi_pkg::CfgW-1:0]  slots_reg;
  logic [rhhi_pkg::CfgW-1:0]  prime_reg;

  result_t                   pending_q[$];
  logic [rhhi_pkg::KeyW-1:0] recent_keys[$];
  int unsigned     errors, words_out, n_ins, n_read, n_full, n_range, n_zero;
  int unsigned     idle_cycles;
  bit              quiet;
  int unsigned     stall_left;

  robin_hood_hash_insert_unit i_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .cmd_i, .key_i, .payload_i, .slot_i,
    .out_valid_o, .out_ready_i, .status_o, .placed_slot_o, .read_key_o,
    .read_payload_o, .read_distance_o, .load_reached_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned active_slots();
    if (slots_reg == 0) return 1;
    if (slots_reg > rhhi_pkg::MaxSlots) return rhhi_pkg::MaxSlots;
    return 32'(slots_reg);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // apply one command to the bench table and work out its result word
  task automatic table_step(input logic cmd, input logic [rhhi_pkg::KeyW-1:0] key,
                            input logic [rhhi_pkg::PayW-1:0] pay,
                            input logic [rhhi_pkg::SlotW-1:0] slot,
                            output result_t res);
    int unsigned n, pos, cdist, step;
    logic [63:0] p;
    logic [rhhi_pkg::KeyW-1:0] ckey, tk;
    logic [rhhi_pkg::PayW-1:0] cpay, tp;
    logic [rhhi_pkg::DistW-1:0] td;
    bit rested;
    n = active_slots();
    res = '0;
    if (cmd == rhhi_pkg::CmdRead) begin
      n_read++;
      if (slot >= n) begin
        res.status = rhhi_pkg::StRange;
        n_range++;
      end else begin
        res.rkey  = key_tbl[slot];
        res.rpay  = pay_tbl[slot];
        res.rdist = dist_tbl[slot];
      end
    end else if (key == 0) begin
      res.status = rhhi_pkg::StZeroKey;
      n_zero++;
    end else if (entries >= n) begin
      res.status = rhhi_pkg::StFull;
      n_full++;
    end else begin
      n_ins++;
      p = (prime_reg == 0) ? 64'd1 : 64'(prime_reg);
      pos = 32'((64'(key) % p) % 64'(n));
      ckey = key;
      cpay = pay;
      cdist = 0;
      rested = 1'b0;
      for (step = 0; step < n; step++) begin
        if (key_tbl[pos] == 0) begin
          key_tbl[pos]  = ckey;
          pay_tbl[pos]  = cpay;
          dist_tbl[pos] = rhhi_pkg::DistW'(cdist);
          held_key[pos] = 1'b1;
          if (!rested) res.placed = rhhi_pkg::SlotW'(pos);
          entries++;
          break;
        end
        if (dist_tbl[pos] < cdist) begin
          tk = key_tbl[pos];
          tp = pay_tbl[pos];
          td = dist_tbl[pos];
          key_tbl[pos]  = ckey;
          pay_tbl[pos]  = cpay;
          dist_tbl[pos] = rhhi_pkg::DistW'(cdist);
          ckey  = tk;
          cpay  = tp;
          cdist = 32'(td);
          if (!rested) begin
            res.placed = rhhi_pkg::SlotW'(pos);
            rested = 1'b1;
          end
        end
        cdist++;
        pos = (pos + 1 >= n) ? 0 : pos + 1;
      end
    end
    res.load = (entries * 4 >= n * 3);
  endtask

  task automatic send_word(input logic cmd, input logic [rhhi_pkg::KeyW-1:0] key,
                           input logic [rhhi_pkg::PayW-1:0] pay,
                           input logic [rhhi_pkg::SlotW-1:0] slot,
                           input bit fixed, input result_t fix_res);
    result_t res;
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    key_i      <= key;
    payload_i  <= pay;
    slot_i     <= slot;
    do @(posedge clk_i); while (!in_ready_o);
    table_step(cmd, key, pay, slot, res);
    pending_q.push_back(fixed ? fix_res : res);
    if (cmd == rhhi_pkg::CmdInsert && key != 0) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > 16) void'(recent_keys.pop_front());
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [rhhi_pkg::CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == rhhi_pkg::RegSlots) slots_reg = val;
    else prime_reg = val;
  endtask

  task automatic set_table(input logic [rhhi_pkg::CfgW-1:0] slots,
                           input logic [rhhi_pkg::CfgW-1:0] prime);
    drain();
    write_reg(rhhi_pkg::RegSlots, slots);
    write_reg(rhhi_pkg::RegPrime, prime);
    @(posedge clk_i);
  endtask

  // random word: mostly inserts with clustered keys, plus slot reads
  task automatic random_word();
    int unsigned r, n, tries, s;
    logic [rhhi_pkg::KeyW-1:0] key;
    logic [rhhi_pkg::PayW-1:0] pay;
    bit found;
    n = active_slots();
    r = $urandom_range(0, 99);
    pay = $urandom;
    if (r < 30) begin
      found = 1'b0;
      if (n < rhhi_pkg::MaxSlots && $urandom_range(0, 3) == 0) begin
        s = $urandom_range(n, rhhi_pkg::MaxSlots - 1);
        found = 1'b1;
      end
      for (tries = 0; tries < 40 && !found; tries++) begin
        s = $urandom_range(0, n - 1);
        found = held_key[s];
      end
      // only slots that once held a key are read in range
      if (found) begin
        send_word(rhhi_pkg::CmdRead, rhhi_pkg::KeyW'({$urandom, $urandom}), pay,
                  rhhi_pkg::SlotW'(s), 1'b0, '0);
        return;
      end
    end
    r = $urandom_range(0, 99);
    if (r < 4) key = '0;
    else if (r < 40) key = rhhi_pkg::KeyW'({$urandom, $urandom});
    else if (r < 70) key = rhhi_pkg::KeyW'($urandom_range(1, 4000));
    else if (r < 85)
      key = rhhi_pkg::KeyW'(((prime_reg == 0) ? 1 : prime_reg) * $urandom_range(1, 500));
    else if (recent_keys.size() != 0)
      key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    else key = rhhi_pkg::KeyW'({$urandom, $urandom});
    if (r >= 4 && key == 0) key = rhhi_pkg::KeyW'(1);
    send_word(rhhi_pkg::CmdInsert, key, pay, rhhi_pkg::SlotW'($urandom), 1'b0, '0);
  endtask

  // output side: random stalls, a few long ones
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_out++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, status %0d", $time, status_o);
      end else begin
        want = pending_q.pop_front();
        if (status_o !== want.status) begin
          errors++;
          $display("%0t: status exp %0d got %0d", $time, want.status, status_o);
        end
        if (placed_slot_o !== want.placed) begin
          errors++;
          $display("%0t: placed_slot exp %0d got %0d", $time, want.placed, placed_slot_o);
        end
        if (read_key_o !== want.rkey) begin
          errors++;
          $display("%0t: read_key exp %h got %h", $time, want.rkey, read_key_o);
        end
        if (read_payload_o !== want.rpay) begin
          errors++;
          $display("%0t: read_payload exp %h got %h", $time, want.rpay, read_payload_o);
        end
        if (read_distance_o !== want.rdist) begin
          errors++;
          $display("%0t: read_distance exp %0d got %0d", $time, want.rdist,
                   read_distance_o);
        end
        if (load_reached_o !== want.load) begin
          errors++;
          $display("%0t: load_reached exp %0d got %0d", $time, want.load, load_reached_o);
        end
      end
    end
  end

  // watchdog, covers the clearing pass and the longest probe walk
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: timeout, %0d words outstanding", $time, pending_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  row_t directed [] = '{
    // cfg  slots   prime   cmd        key             payload        slot  fix  status    load
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdInsert, 40'd0,   32'h1234_5678, 10'd0, 1'b1,
      rhhi_pkg::StZeroKey, 1'b0},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdInsert, 40'd1021, 32'hAAAA_5555, 10'd0, 1'b0,
      rhhi_pkg::StOk, 1'b0},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdInsert, 40'd2042, 32'h0000_0001, 10'd0, 1'b0,
      rhhi_pkg::StOk, 1'b0},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdInsert, 40'd1,    32'h0000_0000, 10'd0, 1'b0,
      rhhi_pkg::StOk, 1'b0},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdInsert, 40'd2,    32'hFFFF_FFFF, 10'd0, 1'b0,
      rhhi_pkg::StOk, 1'b0},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdInsert, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 10'd0,
      1'b0, rhhi_pkg::StOk, 1'b0},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdInsert, 40'h80_0000_0000, 32'h8000_0000, 10'd0,
      1'b0, rhhi_pkg::StOk, 1'b0},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdRead, 40'd0, 32'd0, 10'd0, 1'b0,
      rhhi_pkg::StOk, 1'b0},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdRead, 40'd0, 32'd0, 10'd1, 1'b0,
      rhhi_pkg::StOk, 1'b0},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdRead, 40'd0, 32'd0, 10'd2, 1'b0,
      rhhi_pkg::StOk, 1'b0},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdRead, 40'd0, 32'd0, 10'd3, 1'b0,
      rhhi_pkg::StOk, 1'b0},
    // table smaller than its entry count
    '{1'b1, 11'd4,  11'd3,  rhhi_pkg::CmdInsert, 40'd5, 32'h5, 10'd0, 1'b1,
      rhhi_pkg::StFull, 1'b1},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdRead, 40'd0, 32'd0, 10'd4, 1'b1,
      rhhi_pkg::StRange, 1'b1},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdRead, 40'd0, 32'd0, 10'd1023, 1'b1,
      rhhi_pkg::StRange, 1'b1},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdRead, 40'd0, 32'd0, 10'd2, 1'b0,
      rhhi_pkg::StOk, 1'b0},
    // zero registers act as one
    '{1'b1, 11'd0,  11'd0,  rhhi_pkg::CmdRead, 40'd0, 32'd0, 10'd0, 1'b0,
      rhhi_pkg::StOk, 1'b0},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdRead, 40'd0, 32'd0, 10'd1, 1'b1,
      rhhi_pkg::StRange, 1'b1},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdInsert, 40'd3, 32'd3, 10'd0, 1'b1,
      rhhi_pkg::StFull, 1'b1},
    // oversized slot register clamps, home reduced again by the slot count
    '{1'b1, 11'd2047, 11'd2047, rhhi_pkg::CmdInsert, 40'd2000, 32'hCAFE_0001, 10'd0, 1'b0,
      rhhi_pkg::StOk, 1'b0},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdInsert, 40'd4047, 32'hCAFE_0002, 10'd0, 1'b0,
      rhhi_pkg::StOk, 1'b0},
    '{1'b0, 11'd0,  11'd0,  rhhi_pkg::CmdRead, 40'd0, 32'd0, 10'd976, 1'b0,
      rhhi_pkg::StOk, 1'b0}
  };

  logic [rhhi_pkg::CfgW-1:0] phase_slots [NumPhases] = '{11'd8, 11'd16, 11'd13, 11'd64,
                                                11'd1, 11'd200, 11'd1024, 11'd2047, 11'd1024};
  logic [rhhi_pkg::CfgW-1:0] phase_prime [NumPhases] = '{11'd7, 11'd13, 11'd16, 11'd61,
                                                11'd1, 11'd199, 11'd1021, 11'd2047, 11'd1024};

  initial begin
    result_t fix_res;
    int unsigned ph, i, gap;
    slots_reg = 11'd1024;
    prime_reg = 11'd1021;
    entries = 0;
    for (i = 0; i < rhhi_pkg::MaxSlots; i++) begin
      key_tbl[i]  = '0;
      pay_tbl[i]  = '0;
      dist_tbl[i] = '0;
      held_key[i] = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) begin
      if (directed[k].do_cfg) set_table(directed[k].cfg_slots, directed[k].cfg_prime);
      fix_res = '0;
      fix_res.status = directed[k].fix_status;
      fix_res.load   = directed[k].fix_load;
      send_word(directed[k].cmd, directed[k].key, directed[k].pay, directed[k].slot,
                directed[k].fixed, fix_res);
      gap = pick_gap();
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end

    for (ph = 0; ph < NumPhases; ph++) begin
      set_table(phase_slots[ph], phase_prime[ph]);
      quiet = (ph % 3 == 1);
      for (i = 0; i < PerPhase; i++) begin
        random_word();
        // hold off until the unit has emptied out
        if (i == PerPhase / 2) begin
          in_valid_i <= 1'b0;
          while (pending_q.size() != 0) @(posedge clk_i);
        end else begin
          gap = pick_gap();
          if (gap != 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
      end
    end
    quiet = 1'b0;
    drain();
    repeat (60) @(posedge clk_i);

    $display("covered %0d inserts placed, %0d reads, %0d refused full, %0d out of range,",
             n_ins, n_read, n_full, n_range);
    $display("%0d zero keys, %0d table settings; %0d result words checked",
             n_zero, NumPhases + 3, words_out);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
